// ===== hw/rtl/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types, register map, tables and helpers of the four-voice sound unit.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int WAVE_BYTES           = 16;
  localparam int WAVE_AW              = $clog2(WAVE_BYTES);
  localparam int TICK_MAX             = 64;
  localparam int FRAME_SEQ_CLOCKS_DEF = 8192;
  localparam int NUM_REGS             = 23;
  localparam int TW                   = 24;  // voice timer width
  localparam int SCW                  = 17;  // sample counter width

  localparam logic [14:0] LFSR_SEED     = 15'h7FFF;
  localparam logic [7:0]  DAC_MASK      = 8'hF8;
  localparam logic [7:0]  STATUS_FIXED  = 8'h70;
  localparam logic [7:0]  READ_IDLE     = 8'hFF;
  localparam logic [14:0] MIX_SCALE     = 15'd68;
  localparam logic [15:0] PERIOD_RESET  = 16'd95;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // register map (low address byte)
  localparam logic [7:0] REG_SWEEP  = 8'h10;
  localparam logic [7:0] REG_P0_LEN = 8'h11;
  localparam logic [7:0] REG_P0_ENV = 8'h12;
  localparam logic [7:0] REG_P0_LO  = 8'h13;
  localparam logic [7:0] REG_P0_HI  = 8'h14;
  localparam logic [7:0] REG_P1_LEN = 8'h16;
  localparam logic [7:0] REG_P1_ENV = 8'h17;
  localparam logic [7:0] REG_P1_LO  = 8'h18;
  localparam logic [7:0] REG_P1_HI  = 8'h19;
  localparam logic [7:0] REG_W_DAC  = 8'h1A;
  localparam logic [7:0] REG_W_LEN  = 8'h1B;
  localparam logic [7:0] REG_W_VOL  = 8'h1C;
  localparam logic [7:0] REG_W_LO   = 8'h1D;
  localparam logic [7:0] REG_W_HI   = 8'h1E;
  localparam logic [7:0] REG_N_LEN  = 8'h20;
  localparam logic [7:0] REG_N_ENV  = 8'h21;
  localparam logic [7:0] REG_N_POLY = 8'h22;
  localparam logic [7:0] REG_N_HI   = 8'h23;
  localparam logic [7:0] REG_MVOL   = 8'h24;
  localparam logic [7:0] REG_PAN    = 8'h25;
  localparam logic [7:0] REG_POWER  = 8'h26;
  localparam logic [7:0] WAVE_BASE  = 8'h30;
  localparam logic [7:0] WAVE_LAST  = 8'h3F;

  localparam logic [7:0] DUTY_BITS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};
  localparam logic [6:0] NOISE_DIV [8] = '{7'd8, 7'd16, 7'd32, 7'd48,
                                           7'd64, 7'd80, 7'd96, 7'd112};
  localparam logic [2:0] WAVE_SHIFT [4] = '{3'd4, 3'd0, 3'd1, 3'd2};
  localparam logic [7:0] READ_MASK [NUM_REGS] = '{
    8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'h7F, 8'hFF,
    8'h9F, 8'hFF, 8'hBF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hBF, 8'h00, 8'h00, 8'h70};

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_READ, S_TICK, S_STEP, S_WAVE_RD, S_WAVE_LD,
    S_OUTS, S_FRAME, S_SWEEP, S_MIX, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic write;
    logic tick;
    logic step;
    logic wave_load;
    logic outs;
    logic frame;
    logic sweep;
    logic mix;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic power_on;
    logic any_due;
  } sts_t;

  // next sweep frequency; bit 11 set means overflow past 2047
  function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
                                             input logic [2:0] shift,
                                             input logic dir);
    logic [11:0] d;
    d = {1'b0, shadow >> shift};
    return dir ? ({1'b0, shadow} - d) : ({1'b0, shadow} + d);
  endfunction

  function automatic logic [11:0] period_base(input logic [10:0] f);
    return 12'd2048 - {1'b0, f};
  endfunction

  function automatic logic [21:0] noise_reload(input logic [7:0] s);
    return 22'(NOISE_DIV[s[2:0]]) << s[7:4];
  endfunction

endpackage

// ===== hw/rtl/fcsg_ram.sv =====
// ----------------------------------------------------------------------------
// fcsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fcsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcsg_ctrl
// Sequencer: walks each item through the datapath and holds the result valid.
// ----------------------------------------------------------------------------
module fcsg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     opcode,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output fcsg_pkg::cmd_t cmd,
  input  fcsg_pkg::sts_t sts
);
  import fcsg_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (op_t'(opcode))
            OP_TICK:  state_next = S_TICK;
            OP_READ:  state_next = S_READ;
            OP_WRITE: state_next = S_WRITE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_READ:    state_next = S_DONE;  // wave RAM read latency
      S_TICK: begin
        if (sts.power_on) begin
          cmd.tick   = 1'b1;
          state_next = S_STEP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_STEP: begin
        if (sts.any_due) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_WAVE_RD;
        end
      end
      S_WAVE_RD: state_next = S_WAVE_LD;
      S_WAVE_LD: begin
        cmd.wave_load = 1'b1;
        state_next    = S_OUTS;
      end
      S_OUTS: begin
        cmd.outs   = 1'b1;
        state_next = S_FRAME;
      end
      S_FRAME: begin
        cmd.frame  = 1'b1;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep  = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = (state != S_IDLE);

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result valid raised outside the finish state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state != S_IDLE))
    else $error("accepted item did not start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/fcsg_datapath.sv =====
// ----------------------------------------------------------------------------
// fcsg_datapath
// Voice state, register file, wave RAM, frame sequencer and mixer.
// ----------------------------------------------------------------------------
module fcsg_datapath #(
  parameter int FRAME_SEQ_CLOCKS = fcsg_pkg::FRAME_SEQ_CLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  fcsg_pkg::cmd_t cmd,
  output fcsg_pkg::sts_t sts,
  input  logic [1:0]     opcode,
  input  logic [7:0]     reg_addr,
  input  logic [7:0]     write_data,
  input  logic [6:0]     tick_clocks,
  input  logic [15:0]    sample_period,
  output logic [7:0]     read_data,
  output logic           sample_valid,
  output logic [14:0]    left_sample,
  output logic [14:0]    right_sample
);
  import fcsg_pkg::*;

  localparam int FCW = $clog2(FRAME_SEQ_CLOCKS + TICK_MAX);
  localparam logic [FCW-1:0] FRAME_LEN = FCW'(FRAME_SEQ_CLOCKS);

  // latched item
  op_t        lop;
  logic [7:0] a, d;
  logic [6:0] lclk;

  // sound state
  logic          power_on;
  logic [7:0]    shadow [NUM_REGS];
  logic [3:0]    ven, dac, len_en;
  logic [10:0]   freq [3];
  logic [TW-1:0] ftim [4];
  logic [1:0]    dsel [2];
  logic [2:0]    dpos [2];
  logic [8:0]    len [4];
  logic [3:0]    einit [3], evol [3];
  logic          edir [3];
  logic [2:0]    eper [3];
  logic [4:0]    etim [3];
  logic [2:0]    sw_per, sw_shift;
  logic          sw_dir, sw_act, sw_neg, sw_pend;
  logic [10:0]   sw_shadow;
  logic [4:0]    sw_tim;
  logic [4:0]    wpos;
  logic [3:0]    wnib;
  logic [1:0]    wvol;
  logic          wstep;
  logic [14:0]   lfsr;
  logic [7:0]    nset;
  logic [3:0]    vout [4];
  logic [FCW-1:0] fcnt;
  logic [2:0]    fstep;
  logic [SCW-1:0] scnt;
  logic [5:0]    mvol;
  logic [7:0]    pan;
  logic          smp;
  logic [8:0]    lm, rm;

  logic [WAVE_BYTES-1:0] wvalid;
  logic                  rvalid;
  logic [7:0]            rdata, rbyte;
  logic [WAVE_AW-1:0]    raddr;

  // decode
  logic          is_wave, is_reg, write_en, power_clear, trig;
  logic [4:0]    sidx;
  logic          hi_hit, env_hit, lo_hit;
  logic [1:0]    hi_v, env_i, env_v, lo_v;
  logic [10:0]   fnew [3];
  logic [11:0]   tsw, snf;
  logic [TW-1:0] trel [4], rel [4];
  logic [3:0]    due;
  logic [14:0]   lfsr_nx;
  logic          lfsr_x;
  logic [4:0]    sw_dec;
  logic [4:0]    edec [3];
  logic [SCW-1:0] per_eff, sdiff;
  logic [5:0]    lsum, rsum;
  logic [7:0]    rdval;

  assign is_wave     = (a >= WAVE_BASE) && (a <= WAVE_LAST);
  assign is_reg      = (a >= REG_SWEEP) && (a <= REG_POWER);
  assign sidx        = 5'(a - REG_SWEEP);
  assign write_en    = cmd.write && power_on && is_reg && (a != REG_POWER);
  assign power_clear = cmd.write && (a == REG_POWER) && !d[7] && power_on;
  assign trig        = write_en && hi_hit && d[7];

  always_comb begin
    hi_hit = 1'b1;
    hi_v   = 2'd0;
    case (a)
      REG_P0_HI: hi_v = 2'd0;
      REG_P1_HI: hi_v = 2'd1;
      REG_W_HI:  hi_v = 2'd2;
      REG_N_HI:  hi_v = 2'd3;
      default:   hi_hit = 1'b0;
    endcase
    env_hit = 1'b1;
    env_i   = 2'd0;
    env_v   = 2'd0;
    case (a)
      REG_P0_ENV: begin env_i = 2'd0; env_v = 2'd0; end
      REG_P1_ENV: begin env_i = 2'd1; env_v = 2'd1; end
      REG_N_ENV:  begin env_i = 2'd2; env_v = 2'd3; end
      default:    env_hit = 1'b0;
    endcase
    lo_hit = 1'b1;
    lo_v   = 2'd0;
    case (a)
      REG_P0_LO: lo_v = 2'd0;
      REG_P1_LO: lo_v = 2'd1;
      REG_W_LO:  lo_v = 2'd2;
      default:   lo_hit = 1'b0;
    endcase
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      fnew[v] = {d[2:0], freq[v][7:0]};
    end
    tsw     = sweep_calc(fnew[0], sw_shift, sw_dir);
    trel[0] = TW'({period_base(fnew[0]), 2'b00});
    trel[1] = TW'({period_base(fnew[1]), 2'b00});
    trel[2] = TW'({period_base(fnew[2]), 1'b0});
    trel[3] = TW'(noise_reload(nset));
    rel[0]  = TW'({period_base(freq[0]), 2'b00});
    rel[1]  = TW'({period_base(freq[1]), 2'b00});
    rel[2]  = TW'({period_base(freq[2]), 1'b0});
    rel[3]  = TW'(noise_reload(nset));
    for (int v = 0; v < 4; v++) begin
      due[v] = ftim[v][TW-1] || (ftim[v] == '0);
    end
    lfsr_x  = lfsr[0] ^ lfsr[1];
    lfsr_nx = {lfsr_x, lfsr[14:1]};
    if (nset[3]) begin
      lfsr_nx[6] = lfsr_x;
    end
    snf    = sweep_calc(sw_shadow, sw_shift, sw_dir);
    sw_dec = sw_tim - 5'd1;
    for (int i = 0; i < 3; i++) begin
      edec[i] = etim[i] - 5'd1;
    end
    per_eff = (sample_period < 16'(TICK_MAX)) ? SCW'(TICK_MAX) : SCW'(sample_period);
    sdiff   = scnt - per_eff;
    lsum    = '0;
    rsum    = '0;
    for (int v = 0; v < 4; v++) begin
      if (pan[v])     rsum = rsum + 6'(vout[v]);
      if (pan[v + 4]) lsum = lsum + 6'(vout[v]);
    end
  end

  assign sts.power_on = power_on;
  assign sts.any_due  = |due;

  // wave RAM
  assign raddr = (lop == OP_READ) ? a[WAVE_AW-1:0] : wpos[WAVE_AW:1];
  assign rbyte = rvalid ? rdata : 8'h00;

  fcsg_ram #(.WIDTH(8), .DEPTH(WAVE_BYTES)) u_wave_ram (
    .clk   (clk),
    .we    (cmd.write && is_wave),
    .waddr (a[WAVE_AW-1:0]),
    .wdata (d),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on <= 1'b0;
      wvalid   <= '0;
      rvalid   <= 1'b0;
    end else begin
      rvalid <= wvalid[raddr];
      if (cmd.write && (a == REG_POWER)) begin
        power_on <= d[7];
      end
      if (cmd.write && is_wave) begin
        wvalid[a[WAVE_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lop  <= op_t'(opcode);
      a    <= reg_addr;
      d    <= write_data;
      lclk <= (tick_clocks > 7'(TICK_MAX)) ? 7'(TICK_MAX) : tick_clocks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || power_clear) begin
      for (int i = 0; i < NUM_REGS; i++) shadow[i] <= '0;
      ven    <= '0;
      dac    <= '0;
      len_en <= '0;
      for (int v = 0; v < 4; v++) begin
        ftim[v] <= '0;
        len[v]  <= '0;
        vout[v] <= '0;
      end
      for (int v = 0; v < 3; v++) begin
        freq[v]  <= '0;
        einit[v] <= '0;
        evol[v]  <= '0;
        edir[v]  <= 1'b0;
        eper[v]  <= '0;
        etim[v]  <= '0;
      end
      for (int v = 0; v < 2; v++) begin
        dsel[v] <= '0;
        dpos[v] <= '0;
      end
      sw_per    <= '0;
      sw_shift  <= '0;
      sw_dir    <= 1'b0;
      sw_act    <= 1'b0;
      sw_neg    <= 1'b0;
      sw_pend   <= 1'b0;
      sw_shadow <= '0;
      sw_tim    <= '0;
      wpos      <= '0;
      wnib      <= '0;
      wvol      <= '0;
      wstep     <= 1'b0;
      lfsr      <= LFSR_SEED;
      nset      <= '0;
      fcnt      <= '0;
      fstep     <= '0;
      scnt      <= '0;
      mvol      <= '0;
      pan       <= '0;
    end else begin
      if (write_en) begin
        shadow[sidx] <= d;
        case (a)
          REG_SWEEP: begin
            sw_per   <= d[6:4];
            sw_dir   <= d[3];
            sw_shift <= d[2:0];
            if (!d[3] && sw_neg) ven[0] <= 1'b0;
          end
          REG_P0_LEN: begin
            dsel[0] <= d[7:6];
            len[0]  <= 9'd64 - {3'b0, d[5:0]};
          end
          REG_P1_LEN: begin
            dsel[1] <= d[7:6];
            len[1]  <= 9'd64 - {3'b0, d[5:0]};
          end
          REG_W_DAC: begin
            dac[2] <= d[7];
            if (!d[7]) ven[2] <= 1'b0;
          end
          REG_W_LEN:  len[2] <= 9'd256 - {1'b0, d};
          REG_W_VOL:  wvol <= d[6:5];
          REG_N_LEN:  len[3] <= 9'd64 - {3'b0, d[5:0]};
          REG_N_POLY: nset <= d;
          REG_MVOL:   mvol <= {d[6:4], d[2:0]};
          REG_PAN:    pan <= d;
          default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
          if (env_hit && env_i == 2'(i)) begin
            einit[i] <= d[7:4];
            edir[i]  <= d[3];
            eper[i]  <= d[2:0];
          end
          if (lo_hit && lo_v == 2'(i)) begin
            freq[i][7:0] <= d;
          end
          if (hi_hit && hi_v == 2'(i)) begin
            freq[i][10:8] <= d[2:0];
          end
        end
        for (int v = 0; v < 4; v++) begin
          if (env_hit && env_v == 2'(v)) begin
            dac[v] <= |(d & DAC_MASK);
            if (!(|(d & DAC_MASK))) ven[v] <= 1'b0;
          end
          if (hi_hit && hi_v == 2'(v)) begin
            len_en[v] <= d[6];
            if (d[7]) begin
              ven[v]  <= dac[v] && !(v == 0 && sw_shift != 3'd0 && tsw[11]);
              ftim[v] <= trel[v];
              if (len[v] == 9'd0) len[v] <= (v == 2) ? 9'd256 : 9'd64;
            end
          end
        end
        if (trig) begin
          case (hi_v)
            2'd0: begin
              evol[0]   <= einit[0];
              etim[0]   <= (eper[0] != 3'd0) ? {2'b0, eper[0]} : 5'd8;
              sw_shadow <= fnew[0];
              sw_tim    <= (sw_per != 3'd0) ? {2'b0, sw_per} : 5'd8;
              sw_neg    <= (sw_shift != 3'd0) && sw_dir;
              sw_act    <= (sw_per != 3'd0) || (sw_shift != 3'd0);
            end
            2'd1: begin
              evol[1] <= einit[1];
              etim[1] <= (eper[1] != 3'd0) ? {2'b0, eper[1]} : 5'd8;
            end
            2'd2: wpos <= '0;
            default: begin
              evol[2] <= einit[2];
              etim[2] <= (eper[2] != 3'd0) ? {2'b0, eper[2]} : 5'd8;
              lfsr    <= LFSR_SEED;
            end
          endcase
        end
      end

      if (cmd.tick) begin
        for (int v = 0; v < 4; v++) begin
          ftim[v] <= ftim[v] - TW'(lclk);
        end
        fcnt  <= fcnt + FCW'(lclk);
        scnt  <= scnt + SCW'(lclk);
        wstep <= 1'b0;
      end

      // one reload per due voice each cycle
      if (cmd.step) begin
        for (int v = 0; v < 2; v++) begin
          if (due[v]) begin
            ftim[v] <= ftim[v] + rel[v];
            dpos[v] <= dpos[v] + 3'd1;
          end
        end
        if (due[2]) begin
          ftim[2] <= ftim[2] + rel[2];
          wpos    <= wpos + 5'd1;
          wstep   <= 1'b1;
        end
        if (due[3]) begin
          ftim[3] <= ftim[3] + rel[3];
          lfsr    <= lfsr_nx;
        end
      end

      if (cmd.wave_load && wstep) begin
        wnib <= wpos[0] ? rbyte[3:0] : rbyte[7:4];
      end

      if (cmd.outs) begin
        for (int v = 0; v < 2; v++) begin
          vout[v] <= (ven[v] && dac[v] && DUTY_BITS[dsel[v]][dpos[v]]) ? evol[v] : 4'd0;
        end
        vout[2] <= (ven[2] && dac[2]) ? (wnib >> WAVE_SHIFT[wvol]) : 4'd0;
        vout[3] <= (ven[3] && dac[3] && !lfsr[0]) ? evol[2] : 4'd0;
      end

      if (cmd.frame && (fcnt >= FRAME_LEN)) begin
        fcnt  <= fcnt - FRAME_LEN;
        fstep <= fstep + 3'd1;
        if (!fstep[0]) begin
          for (int v = 0; v < 4; v++) begin
            if (len_en[v] && len[v] != 9'd0) begin
              len[v] <= len[v] - 9'd1;
              if (len[v] == 9'd1) ven[v] <= 1'b0;
            end
          end
          // sweep on steps 2 and 6
          if (fstep[1] && sw_act && sw_per != 3'd0) begin
            if (!sw_dec[4] && sw_dec != 5'd0) begin
              sw_tim <= sw_dec;
            end else begin
              sw_tim <= {2'b0, sw_per};
              if (sw_dir) sw_neg <= 1'b1;
              if (snf[11]) begin
                ven[0] <= 1'b0;
              end else if (sw_shift != 3'd0) begin
                sw_shadow <= snf[10:0];
                freq[0]   <= snf[10:0];
                sw_pend   <= 1'b1;
              end
            end
          end
        end else if (fstep == 3'd7) begin
          for (int i = 0; i < 3; i++) begin
            if (eper[i] != 3'd0) begin
              if (!edec[i][4] && edec[i] != 5'd0) begin
                etim[i] <= edec[i];
              end else begin
                etim[i] <= {2'b0, eper[i]};
                if (edir[i] && evol[i] != 4'd15) evol[i] <= evol[i] + 4'd1;
                else if (!edir[i] && evol[i] != 4'd0) evol[i] <= evol[i] - 4'd1;
              end
            end
          end
        end
      end

      // second overflow check on the updated shadow
      if (cmd.sweep && sw_pend) begin
        sw_pend <= 1'b0;
        if (sw_dir) sw_neg <= 1'b1;
        if (snf[11]) ven[0] <= 1'b0;
      end

      if (cmd.mix && (scnt >= per_eff)) begin
        scnt <= (sdiff >= per_eff) ? '0 : sdiff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp <= 1'b0;
    end else if (cmd.latch) begin
      smp <= 1'b0;
    end else if (cmd.mix && (scnt >= per_eff)) begin
      smp <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      lm <= {3'b0, lsum} * {5'b0, {1'b0, mvol[5:3]} + 4'd1};
      rm <= {3'b0, rsum} * {5'b0, {1'b0, mvol[2:0]} + 4'd1};
    end
  end

  always_comb begin
    if (is_wave) begin
      rdval = rbyte;
    end else if (a == REG_POWER) begin
      rdval = {power_on, 7'b0} | STATUS_FIXED | {4'b0, ven};
    end else if (is_reg) begin
      rdval = shadow[sidx] | READ_MASK[sidx];
    end else begin
      rdval = READ_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      read_data    <= (lop == OP_READ) ? rdval : READ_IDLE;
      sample_valid <= smp;
      left_sample  <= smp ? ({6'b0, lm} * MIX_SCALE) : 15'd0;
      right_sample <= smp ? ({6'b0, rm} * MIX_SCALE) : 15'd0;
    end
  end

endmodule

// ===== hw/rtl/four_channel_sound_generator.sv =====
// ----------------------------------------------------------------------------
// four_channel_sound_generator
// Four-voice sound unit: bus reads/writes and clock ticks in, samples out.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   opcode, reg_addr, write_data, tick_clocks
//   out      output     out_valid/out_stall read_data, sample_valid, left/right_sample
//   cfg      input      APB                 sample_period (read at address 0)
//
// A read or write passes one state before the finish state; a powered tick repeats
// the reload state while a voice is due, then wave read/load, outs, frame, sweep, mix.
// One item is in flight; the next is taken once the result is registered.
// Reset is synchronous; wave RAM reads back zero until an entry is written.
// A stalled result holds the finish state until taken.
// ----------------------------------------------------------------------------
module four_channel_sound_generator #(
  parameter int FRAME_SEQ_CLOCKS = fcsg_pkg::FRAME_SEQ_CLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic [6:0]  tick_clocks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        sample_valid,
  output logic [14:0] left_sample,
  output logic [14:0] right_sample
);
  import fcsg_pkg::*;

  logic [15:0] sample_period;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'b0, sample_period} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (psel && penable && pwrite) begin
      sample_period <= pwdata[15:0];
    end
  end

  fcsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fcsg_datapath #(.FRAME_SEQ_CLOCKS(FRAME_SEQ_CLOCKS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .reg_addr      (reg_addr),
    .write_data    (write_data),
    .tick_clocks   (tick_clocks),
    .sample_period (sample_period),
    .read_data     (read_data),
    .sample_valid  (sample_valid),
    .left_sample   (left_sample),
    .right_sample  (right_sample)
  );

endmodule
